/* rtl/core/lidd_pkg.sv */
// Shared constants and types for the length/id prefixed deframer.
package lidd_pkg;

  // Header is a 32-bit little-endian length followed by a 32-bit id
  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned PosWidth    = $clog2(HeaderBytes + 1);
  localparam int unsigned LenBytes    = 4;

  localparam logic [PosWidth-1:0] PosFirst   = '0;
  localparam logic [PosWidth-1:0] PosLastHdr = PosWidth'(HeaderBytes - 1);
  localparam logic [PosWidth-1:0] PosPayload = PosWidth'(HeaderBytes);
  localparam logic [PosWidth-1:0] PosIdFirst = PosWidth'(LenBytes);

  // One result item as produced by the parser
  typedef struct packed {
    logic        valid;
    logic [7:0]  payload_byte;
    logic [31:0] message_id;
    logic        last_of_message;
    logic        empty_message;
  } lidd_result_t;

endpackage

/* rtl/core/lidd_parse.sv */
// Header/payload parser: holds the framing state and forms at most one result per byte.
module lidd_parse import lidd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         advance_i,
  input  logic [7:0]   data_byte_i,
  output lidd_result_t result_o
);

  logic [PosWidth-1:0] pos_q, pos_d;
  logic [31:0]         len_q, len_d;
  logic [31:0]         id_q, id_d;
  logic [31:0]         rem_q, rem_d;

  logic                in_header;
  logic [4:0]          lane_sel;
  logic [31:0]         len_base, id_base;
  logic [31:0]         len_new, id_new;

  assign in_header = (pos_q < PosPayload);
  // byte lane within the 32-bit word being assembled
  assign lane_sel  = {pos_q[1:0], 3'b000};

  // Header assembly and payload countdown
  always_comb begin
    len_base = (pos_q == PosFirst) ? 32'd0 : len_q;
    id_base  = (pos_q == PosFirst) ? 32'd0 : id_q;
    len_new  = len_base;
    id_new   = id_base;
    pos_d    = pos_q;
    len_d    = len_q;
    id_d     = id_q;
    rem_d    = rem_q;
    result_o = '0;
    result_o.message_id = id_q;

    if (in_header) begin
      if (pos_q < PosIdFirst) begin
        len_new[lane_sel +: 8] = data_byte_i;
      end else begin
        id_new[lane_sel +: 8] = data_byte_i;
      end
      len_d = len_new;
      id_d  = id_new;
      pos_d = pos_q + PosWidth'(1);
      if (pos_q == PosLastHdr) begin
        if (len_new == 32'd0) begin
          // empty message: one flagged item, then back to header
          pos_d = PosFirst;
          rem_d = 32'd0;
          result_o.valid           = 1'b1;
          result_o.message_id      = id_new;
          result_o.last_of_message = 1'b1;
          result_o.empty_message   = 1'b1;
        end else begin
          rem_d = len_new;
        end
      end
    end else begin
      // payload byte (positions past the header all count as payload)
      result_o.valid        = 1'b1;
      result_o.payload_byte = data_byte_i;
      if (rem_q <= 32'd1) begin
        rem_d = 32'd0;
        pos_d = PosFirst;
        result_o.last_of_message = 1'b1;
      end else begin
        rem_d = rem_q - 32'd1;
      end
    end
  end

  // Framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosFirst;
      len_q <= '0;
      id_q  <= '0;
      rem_q <= '0;
    end else if (advance_i) begin
      pos_q <= pos_d;
      len_q <= len_d;
      id_q  <= id_d;
      rem_q <= rem_d;
    end
  end

endmodule

/* rtl/core/length_id_prefixed_deframer_unit.sv */
// Top level of the length/id prefixed deframer.
//
// Usage: raw stream bytes enter on data_byte_i, one item per in_valid_i &&
// in_ready_o edge. Each message is an 8-byte header (32-bit little-endian
// length, then 32-bit little-endian id) followed by the payload. Every
// payload byte leaves as one item tagged with the id; the final byte has
// last_of_message_o set. A zero-length message gives one item with payload 0
// and both last_of_message_o and empty_message_o set. Header bytes otherwise
// give no item.
// A result is shown from the output register in the cycle after its byte is
// accepted. One byte per cycle is taken while the receiver takes results, as
// the single output register is refilled in the same cycle it is drained.
// Reset clears the framing state (next byte is taken as the first header
// byte) and empties the output register. When the receiver stalls with a
// result held, in_ready_o drops and the parser state holds until the result
// is taken.
module length_id_prefixed_deframer_unit import lidd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  payload_byte_o,
  output logic [31:0] message_id_o,
  output logic        last_of_message_o,
  output logic        empty_message_o
);

  lidd_result_t res;
  logic         accept;
  logic         out_valid_q;
  logic [7:0]   byte_q;
  logic [31:0]  id_q;
  logic         last_q;
  logic         empty_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  lidd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (accept),
    .data_byte_i (data_byte_i),
    .result_o    (res)
  );

  // Output register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= accept && res.valid;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (accept && res.valid) begin
      byte_q  <= res.payload_byte;
      id_q    <= res.message_id;
      last_q  <= res.last_of_message;
      empty_q <= res.empty_message;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign payload_byte_o    = byte_q;
  assign message_id_o      = id_q;
  assign last_of_message_o = last_q;
  assign empty_message_o   = empty_q;

endmodule

/* bench/length_id_prefixed_deframer_unit_tb.sv */
// Testbench for the length/id prefixed deframer: directed and random byte streams.
`timescale 1ns / 1ps

module length_id_prefixed_deframer_unit_tb import lidd_pkg::*; ();

  localparam int unsigned ClkHalf       = 6;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned RandomItems   = 1200;
  localparam int unsigned MaxReported   = 10;

  typedef enum logic [1:0] {RxAlways, RxCoin, RxMostly, RxRare} rx_mode_e;

  // one deframed payload item as the block should emit it
  typedef struct {
    logic [7:0]  payload_byte;
    logic [31:0] message_id;
    logic        last_of_message;
    logic        empty_message;
  } deframed_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  payload_byte_o;
  logic [31:0] message_id_o;
  logic        last_of_message_o;
  logic        empty_message_o;

  length_id_prefixed_deframer_unit i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .out_valid_o,
    .out_ready_i,
    .payload_byte_o,
    .message_id_o,
    .last_of_message_o,
    .empty_message_o
  );

  always #ClkHalf clk_i = ~clk_i;

  // framing state of the predictor, reset values
  logic [3:0]  hdr_pos    = '0;
  logic [31:0] msg_len    = '0;
  logic [31:0] msg_id     = '0;
  logic [31:0] bytes_left = '0;

  deframed_t   deframed_q[$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;
  bit          hold_off_req = 1'b0;

  // advance the predicted framing by one stream byte
  task automatic deframe_byte(input logic [7:0] b);
    deframed_t r;
    if (hdr_pos < HeaderBytes) begin
      if (hdr_pos == 0) begin
        msg_len = '0;
        msg_id  = '0;
      end
      if (hdr_pos < LenBytes) msg_len[8*hdr_pos +: 8] = b;
      else msg_id[8*(hdr_pos - LenBytes) +: 8] = b;
      hdr_pos = hdr_pos + 4'd1;
      if (hdr_pos == HeaderBytes) begin
        if (msg_len == 0) begin
          // empty message: single flagged item, back to header
          hdr_pos    = '0;
          bytes_left = '0;
          r.payload_byte    = 8'h00;
          r.message_id      = msg_id;
          r.last_of_message = 1'b1;
          r.empty_message   = 1'b1;
          deframed_q.insert(deframed_q.size(), r);
        end else begin
          bytes_left = msg_len;
        end
      end
    end else begin
      r.payload_byte  = b;
      r.message_id    = msg_id;
      r.empty_message = 1'b0;
      if (bytes_left <= 1) begin
        bytes_left = '0;
        hdr_pos    = '0;
        r.last_of_message = 1'b1;
      end else begin
        bytes_left = bytes_left - 1;
        r.last_of_message = 1'b0;
      end
      deframed_q.insert(deframed_q.size(), r);
    end
  endtask

  // offer one byte, with random gaps between bursts
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = 0;
      if (gaps_on && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    burst_left--;
    bytes_sent++;
    deframe_byte(b);
  endtask

  // little-endian length, then little-endian id
  task automatic push_header(input logic [31:0] len, input logic [31:0] id);
    for (int i = 0; i < 4; i++) push_byte(len[8*i +: 8]);
    for (int i = 0; i < 4; i++) push_byte(id[8*i +: 8]);
  endtask

  task automatic push_message(input logic [31:0] len, input logic [31:0] id);
    push_header(len, id);
    for (int unsigned i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= MaxReported) $display("%0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Tests

  // empty message, one-byte and two-byte messages at field extremes
  task automatic test_directed();
    push_header(32'h0000_0000, 32'hFFFF_FFFF);
    push_header(32'h0000_0001, 32'h0000_0000);
    push_byte(8'hFF);
    push_header(32'h0000_0002, 32'h1234_5678);
    push_byte(8'h00);
    push_byte(8'hA5);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    gaps_on      = 1'b0;
    hold_off_req = 1'b1;
    push_message(32'd60, 32'($urandom));
    gaps_on      = 1'b1;
  endtask

  // back-to-back messages, mostly short, some empty
  task automatic test_random_stream();
    int unsigned stop_at;
    int unsigned pick;
    logic [31:0] len;
    stop_at = bytes_sent + RandomItems;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) len = 0;
      else if (pick < 75) len = $urandom_range(1, 8);
      else if (pick < 95) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 200);
      push_message(len, 32'($urandom));
    end
  endtask

  // all-ones length: message never completes within the run
  task automatic test_huge_length();
    push_header(32'hFFFF_FFFF, 32'h8000_0001);
    repeat (24) push_byte(8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: changing ready patterns plus one long hold-off
  rx_mode_e    rx_mode = RxAlways;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left    = HoldOffCycles;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 160);
      end
      mode_left--;
      case (rx_mode)
        RxAlways: out_ready_i <= 1'b1;
        RxCoin:   out_ready_i <= 1'($urandom_range(0, 1));
        RxMostly: out_ready_i <= ($urandom_range(0, 7) != 0);
        default:  out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // compare each emitted item with the oldest prediction
  always @(posedge clk_i) begin
    deframed_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (deframed_q.size() == 0) begin
        report($sformatf("unexpected item: byte %02h id %08h last %0b empty %0b",
                         payload_byte_o, message_id_o, last_of_message_o,
                         empty_message_o));
      end else begin
        want = deframed_q.pop_front();
        if (payload_byte_o !== want.payload_byte || message_id_o !== want.message_id ||
            last_of_message_o !== want.last_of_message ||
            empty_message_o !== want.empty_message) begin
          report($sformatf({"mismatch: expected byte %02h id %08h last %0b empty %0b,",
                            " got byte %02h id %08h last %0b empty %0b"},
                           want.payload_byte, want.message_id, want.last_of_message,
                           want.empty_message, payload_byte_o, message_id_o,
                           last_of_message_o, empty_message_o));
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  int unsigned quiet = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= StallLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = 8'h00;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_backpressure();
    test_random_stream();
    test_huge_length();

    // drain outstanding items, then allow for the output register
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (deframed_q.size() != 0);
    repeat (8) @(posedge clk_i);
    if (deframed_q.size() != 0) report("items still expected at end of run");

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* length_id_prefixed_deframer_unit.f */
rtl/core/lidd_pkg.sv
rtl/core/lidd_parse.sv
rtl/core/length_id_prefixed_deframer_unit.sv
bench/length_id_prefixed_deframer_unit_tb.sv
